FILE: sv/pcs_pkg.sv
// pcs_pkg: shared types, constants and register codes for the paddle
// calibration sequencer
// no dependencies
`default_nettype none

package pcs_pkg;

    localparam int AVG_LOG2 = 7;
    localparam int SUM_W    = AVG_LOG2 + 8;
    localparam int COUNT_W  = AVG_LOG2 + 1;
    localparam logic [COUNT_W-1:0] AVG_COUNT = COUNT_W'(1) << AVG_LOG2;

    localparam logic [2:0] PH_CENTER     = 3'd0;
    localparam logic [2:0] PH_WAIT_LOW   = 3'd1;
    localparam logic [2:0] PH_GRACE_LOW  = 3'd2;
    localparam logic [2:0] PH_LOW        = 3'd3;
    localparam logic [2:0] PH_WAIT_HIGH  = 3'd4;
    localparam logic [2:0] PH_GRACE_HIGH = 3'd5;
    localparam logic [2:0] PH_HIGH       = 3'd6;
    localparam logic [2:0] PH_DONE       = 3'd7;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_TICKS   = 2'd2;

    localparam logic [7:0]  RST_STABLE_WINDOW = 8'd10;
    localparam logic [7:0]  RST_CHANGE_MARGIN = 8'd20;
    localparam logic [15:0] RST_GRACE_TICKS   = 16'd1000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] sample;
    } in_t;

    typedef struct packed {
        logic [2:0] phase_now;
        logic       finished;
        logic [7:0] progress;
        logic [7:0] center_avg;
        logic [7:0] low_end_avg;
        logic [7:0] high_end_avg;
    } out_t;

    typedef struct packed {
        logic [7:0]  stable_window;
        logic [7:0]  change_margin;
        logic [15:0] grace_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         phase;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
        logic [7:0]         prev;
        logic [7:0]         center;
        logic [7:0]         low;
        logic [7:0]         high;
        logic [15:0]        elapsed;
        logic               done;
    } state_t;

endpackage

`default_nettype wire

FILE: sv/paddle_calibration_sequencer.sv
// paddle_calibration_sequencer: top level, state and result registers
// result: the result word of an accepted word is registered and appears in the next cycle
// throughput: one word per cycle while the output is not stalled, limited by the single next-state stage
// reset: asynchronous active-low, center phase, all sums and averages zero,
// registers at 10 / 20 / 1000
// depends on pcs_pkg, pcs_cfg, pcs_step
`default_nettype none

module paddle_calibration_sequencer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire pcs_pkg::in_t                      in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output pcs_pkg::out_t                          out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pcs_pkg::cfg_t   cfg;
    pcs_pkg::state_t state_reg;
    pcs_pkg::state_t state_next;
    pcs_pkg::state_t step_state;
    pcs_pkg::out_t   out_data_reg;
    pcs_pkg::out_t   out_data_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            in_accept;

    pcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcs_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .word       (in_data),
        .state_next (step_state)
    );

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = in_accept ? step_state : state_reg;
        out_valid_next = in_accept || (out_valid_reg && out_stall);

        out_data_next              = out_data_reg;
        out_data_next.phase_now    = step_state.phase;
        out_data_next.finished     = step_state.done;
        out_data_next.progress     = 8'(step_state.count);
        out_data_next.center_avg   = step_state.center;
        out_data_next.low_end_avg  = step_state.low;
        out_data_next.high_end_avg = step_state.high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= out_data_next;
    end

    // ticks never move the phase
    a_tick_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.cmd == pcs_pkg::CMD_TICK) |=> $stable(state_reg.phase))
        else $error("phase changed on a tick");

    // count always below a full average
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count < pcs_pkg::AVG_COUNT)
        else $error("stable count reached full average without advancing");

    // finished only in the done phase
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.done |-> state_reg.phase == pcs_pkg::PH_DONE)
        else $error("done flag outside done phase");

    // state only moves on an accepted word
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(state_reg))
        else $error("state changed without an accepted word");

endmodule

`default_nettype wire

FILE: sv/pcs_cfg.sv
// pcs_cfg: configuration register bank for the calibration sequencer
// depends on pcs_pkg
`default_nettype none

module pcs_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pcs_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pcs_pkg::cfg_t                          cfg
);

    pcs_pkg::cfg_t cfg_reg;
    pcs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pcs_pkg::REG_STABLE_WINDOW: cfg_next.stable_window = cfg_data[7:0];
                pcs_pkg::REG_CHANGE_MARGIN: cfg_next.change_margin = cfg_data[7:0];
                pcs_pkg::REG_GRACE_TICKS:   cfg_next.grace_ticks   = cfg_data[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stable_window <= pcs_pkg::RST_STABLE_WINDOW;
            cfg_reg.change_margin <= pcs_pkg::RST_CHANGE_MARGIN;
            cfg_reg.grace_ticks   <= pcs_pkg::RST_GRACE_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/pcs_step.sv
// pcs_step: next-state logic for one sample or tick word
// depends on pcs_pkg
`default_nettype none

module pcs_step (
    input  wire pcs_pkg::state_t state,
    input  wire pcs_pkg::cfg_t   cfg,
    input  wire pcs_pkg::in_t    word,
    output pcs_pkg::state_t      state_next
);

    logic [7:0]                  diff;
    logic                        stable;
    logic [pcs_pkg::SUM_W-1:0]   sum_add;
    logic [pcs_pkg::COUNT_W-1:0] count_inc;
    logic                        avg_full;
    logic [7:0]                  avg_val;
    logic [8:0]                  low_lhs;
    logic [8:0]                  high_rhs;
    logic                        advance;

    always_comb
    begin
        diff      = (word.sample >= state.prev) ? (word.sample - state.prev)
                                                : (state.prev - word.sample);
        stable    = diff < cfg.stable_window;
        sum_add   = state.sum + pcs_pkg::SUM_W'(word.sample);
        count_inc = state.count + pcs_pkg::COUNT_W'(1);
        avg_full  = count_inc == pcs_pkg::AVG_COUNT;
        avg_val   = 8'(sum_add >> pcs_pkg::AVG_LOG2);
        low_lhs   = {1'b0, word.sample} + {1'b0, cfg.change_margin};
        high_rhs  = {1'b0, state.center} + {1'b0, cfg.change_margin};

        state_next = state;
        advance    = 1'b0;

        if (word.cmd == pcs_pkg::CMD_TICK)
        begin
            if (state.elapsed != 16'hFFFF)
                state_next.elapsed = state.elapsed + 16'd1;
        end
        else if (state.phase == pcs_pkg::PH_DONE)
        begin
            state_next.done = 1'b1;
        end
        else
        begin
            state_next.prev = word.sample;
            case (state.phase)
                pcs_pkg::PH_CENTER, pcs_pkg::PH_LOW, pcs_pkg::PH_HIGH:
                begin
                    if (stable)
                    begin
                        state_next.sum   = sum_add;
                        state_next.count = count_inc;
                        if (avg_full)
                        begin
                            advance = 1'b1;
                            if (state.phase == pcs_pkg::PH_CENTER)
                                state_next.center = avg_val;
                            else if (state.phase == pcs_pkg::PH_LOW)
                                state_next.low = avg_val;
                            else
                                state_next.high = avg_val;
                        end
                    end
                    else
                    begin
                        state_next.sum   = '0;
                        state_next.count = '0;
                    end
                end
                pcs_pkg::PH_WAIT_LOW:  advance = low_lhs < {1'b0, state.center};
                pcs_pkg::PH_WAIT_HIGH: advance = {1'b0, word.sample} > high_rhs;
                default:               advance = state.elapsed >= cfg.grace_ticks;
            endcase
            if (advance)
            begin
                state_next.phase   = state.phase + 3'd1;
                state_next.count   = '0;
                state_next.sum     = '0;
                state_next.elapsed = '0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/paddle_calibration_sequencer_test.sv
// paddle_calibration_sequencer_test: self-checking bench for the calibration sequencer
// drives samples and ticks through a full calibration and checks every status word
// depends on pcs_pkg and paddle_calibration_sequencer

module paddle_calibration_sequencer_test;

    localparam logic [pcs_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS = 800;

    typedef struct packed {
        logic [2:0]                  phase;
        logic [pcs_pkg::COUNT_W-1:0] count;
        logic [pcs_pkg::SUM_W-1:0]   sum;
        logic [7:0]                  prev;
        logic [7:0]                  center;
        logic [7:0]                  low;
        logic [7:0]                  high;
        logic [15:0]                 elapsed;
        logic                        done;
    } calib_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    pcs_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    pcs_pkg::out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    pcs_pkg::in_t pending_words[$];
    pcs_pkg::out_t expected_status[$];
    calib_t cal_now;
    calib_t cal_plan;
    pcs_pkg::cfg_t cal_cfg;
    int errors = 0;
    int quiet_cycles = 0;
    int in_gap = 0;
    int in_calm = 0;
    int out_hold = 0;
    int out_calm = 0;
    bit held_long = 0;
    pcs_pkg::out_t want;
    pcs_pkg::out_t predicted;

    paddle_calibration_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic bump_phase(inout calib_t st);
        if (st.phase != pcs_pkg::PH_DONE)
            st.phase = st.phase + 3'd1;
        st.count = '0;
        st.sum = '0;
        st.elapsed = '0;
    endtask

    task automatic advance_calibration(inout calib_t st, input pcs_pkg::cfg_t c,
                                       input pcs_pkg::in_t w, output pcs_pkg::out_t r);
        logic [7:0] diff;
        logic [7:0] mean;
        if (w.cmd == pcs_pkg::CMD_TICK)
        begin
            if (st.elapsed != 16'hFFFF)
                st.elapsed = st.elapsed + 16'd1;
        end
        else if (st.phase == pcs_pkg::PH_DONE)
            st.done = 1'b1;
        else
        begin
            case (st.phase)
                pcs_pkg::PH_CENTER, pcs_pkg::PH_LOW, pcs_pkg::PH_HIGH:
                begin
                    diff = (w.sample >= st.prev) ? w.sample - st.prev : st.prev - w.sample;
                    if (diff < c.stable_window)
                    begin
                        st.sum = st.sum + pcs_pkg::SUM_W'(w.sample);
                        st.count = st.count + pcs_pkg::COUNT_W'(1);
                        if (st.count == pcs_pkg::AVG_COUNT)
                        begin
                            mean = 8'(st.sum >> pcs_pkg::AVG_LOG2);
                            if (st.phase == pcs_pkg::PH_CENTER)
                                st.center = mean;
                            else if (st.phase == pcs_pkg::PH_LOW)
                                st.low = mean;
                            else
                                st.high = mean;
                            bump_phase(st);
                        end
                    end
                    else
                    begin
                        st.sum = '0;
                        st.count = '0;
                    end
                end
                pcs_pkg::PH_WAIT_LOW:
                    if (int'(w.sample) + int'(c.change_margin) < int'(st.center))
                        bump_phase(st);
                pcs_pkg::PH_WAIT_HIGH:
                    if (int'(w.sample) > int'(st.center) + int'(c.change_margin))
                        bump_phase(st);
                default:
                    if (st.elapsed >= c.grace_ticks)
                        bump_phase(st);
            endcase
            st.prev = w.sample;
        end
        r.phase_now = st.phase;
        r.finished = st.done;
        r.progress = st.count;
        r.center_avg = st.center;
        r.low_end_avg = st.low;
        r.high_end_avg = st.high;
    endtask

    // mostly short pauses, a few long ones, and calm stretches with none
    task automatic draw_pause(inout int calm, output int pause);
        int r;
        r = $urandom_range(0, 99);
        pause = 0;
        if (calm > 0)
            calm = calm - 1;
        else if (r < 3)
            calm = $urandom_range(20, 80);
        else if (r < 55)
            pause = 0;
        else if (r < 88)
            pause = $urandom_range(1, 3);
        else if (r < 97)
            pause = $urandom_range(4, 12);
        else
            pause = $urandom_range(20, 50);
    endtask

    task automatic flag_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] got_val);
        errors = errors + 1;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
    endtask

    task automatic queue_item(input logic cmd, input logic [7:0] s);
        pcs_pkg::in_t w;
        pcs_pkg::out_t scratch;
        w.cmd = cmd;
        w.sample = s;
        advance_calibration(cal_plan, cal_cfg, w, scratch);
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input logic [pcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcs_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            pcs_pkg::REG_STABLE_WINDOW: cal_cfg.stable_window = val[7:0];
            pcs_pkg::REG_CHANGE_MARGIN: cal_cfg.change_margin = val[7:0];
            pcs_pkg::REG_GRACE_TICKS:   cal_cfg.grace_ticks = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        do @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_status.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    function automatic pcs_pkg::in_t gen_item(input calib_t p, input pcs_pkg::cfg_t c,
                                              input logic [7:0] base, input bit noisy);
        pcs_pkg::in_t w;
        int h;
        int lo;
        int hi;
        int thr;
        w.cmd = pcs_pkg::CMD_SAMPLE;
        w.sample = 8'($urandom_range(0, 255));
        case (p.phase)
            pcs_pkg::PH_CENTER, pcs_pkg::PH_LOW, pcs_pkg::PH_HIGH:
            begin
                if ($urandom_range(0, 9) == 0)
                    w.cmd = pcs_pkg::CMD_TICK;
                else if (!(noisy && $urandom_range(0, 29) == 0))
                begin
                    h = (c.stable_window == 0) ? 0 : (int'(c.stable_window) - 1) / 2;
                    lo = (int'(base) - h < 0) ? 0 : int'(base) - h;
                    hi = (int'(base) + h > 255) ? 255 : int'(base) + h;
                    w.sample = 8'($urandom_range(lo, hi));
                end
            end
            pcs_pkg::PH_WAIT_LOW:
            begin
                thr = int'(p.center) - int'(c.change_margin);
                if ($urandom_range(0, 9) == 0)
                    w.cmd = pcs_pkg::CMD_TICK;
                else if (thr > 0 && $urandom_range(0, 5) == 0)
                    w.sample = 8'($urandom_range(0, thr - 1));
                else if (thr >= 0)
                    w.sample = 8'($urandom_range(thr, 255));
            end
            pcs_pkg::PH_WAIT_HIGH:
            begin
                thr = int'(p.center) + int'(c.change_margin);
                if ($urandom_range(0, 9) == 0)
                    w.cmd = pcs_pkg::CMD_TICK;
                else if (thr < 255 && $urandom_range(0, 5) == 0)
                    w.sample = 8'($urandom_range(thr + 1, 255));
                else if (thr <= 255)
                    w.sample = 8'($urandom_range(0, thr));
            end
            pcs_pkg::PH_GRACE_LOW, pcs_pkg::PH_GRACE_HIGH:
                if ($urandom_range(0, 3) != 0)
                    w.cmd = pcs_pkg::CMD_TICK;
            default:
                w.cmd = 1'($urandom_range(0, 1));
        endcase
        return w;
    endfunction

    // driver: one word in flight, next word raised in the same step it is accepted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_calibration(cal_now, cal_cfg, in_data, predicted);
                expected_status.push_back(predicted);
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_words.pop_front();
                    draw_pause(in_calm, in_gap);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks status words and stalls the output side
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: status word with nothing expected, got %h", $time,
                             out_data);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (out_data.phase_now !== want.phase_now)
                        flag_field("phase_now", want.phase_now, out_data.phase_now);
                    if (out_data.finished !== want.finished)
                        flag_field("finished", want.finished, out_data.finished);
                    if (out_data.progress !== want.progress)
                        flag_field("progress", want.progress, out_data.progress);
                    if (out_data.center_avg !== want.center_avg)
                        flag_field("center_avg", want.center_avg, out_data.center_avg);
                    if (out_data.low_end_avg !== want.low_end_avg)
                        flag_field("low_end_avg", want.low_end_avg, out_data.low_end_avg);
                    if (out_data.high_end_avg !== want.high_end_avg)
                        flag_field("high_end_avg", want.high_end_avg, out_data.high_end_avg);
                end
            end
            // one long hold while the sender keeps offering, to back up the block
            if (!held_long && out_hold == 0 && pending_words.size() > 40)
            begin
                held_long = 1;
                out_hold = 150;
            end
            if (out_hold == 0)
                draw_pause(out_calm, out_hold);
            out_stall <= (out_hold > 0);
            if (out_hold > 0)
                out_hold = out_hold - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int random_words;
        int segment;
        int r;
        bit hit_boundary;
        bit noisy;
        logic [2:0] last_phase;
        logic [7:0] base;
        logic [7:0] window;
        logic [7:0] margin;
        logic [15:0] grace;
        pcs_pkg::in_t w;
        random_words = 0;
        segment = 0;
        hit_boundary = 0;
        last_phase = pcs_pkg::PH_DONE;
        base = 8'd127;
        window = 8'd10;
        cal_now = '0;
        cal_plan = '0;
        cal_cfg.stable_window = pcs_pkg::RST_STABLE_WINDOW;
        cal_cfg.change_margin = pcs_pkg::RST_CHANGE_MARGIN;
        cal_cfg.grace_ticks = pcs_pkg::RST_GRACE_TICKS;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // stability edges at the reset settings, field extremes, ignored tick payload
        @(negedge clk);
        queue_item(pcs_pkg::CMD_TICK, 8'hFF);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd0);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd9);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd19);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd255);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd255);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd246);
        queue_item(pcs_pkg::CMD_TICK, 8'h00);
        queue_item(pcs_pkg::CMD_TICK, 8'hAA);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd0);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd127);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd128);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'hAA);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'h55);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'h55);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd1);
        wait_drained;

        // zero window: even repeated samples are unstable; spare index is ignored
        write_reg(REG_SPARE, 16'($urandom));
        write_reg(pcs_pkg::REG_STABLE_WINDOW, {8'($urandom), 8'd0});
        @(negedge clk);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd85);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd85);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd85);
        queue_item(pcs_pkg::CMD_TICK, 8'd85);
        queue_item(pcs_pkg::CMD_SAMPLE, 8'd200);
        wait_drained;

        while (random_words < RANDOM_WORDS && segment < 400)
        begin
            // level and window stay put within a phase so averages can complete
            if (cal_plan.phase != last_phase)
            begin
                r = $urandom_range(0, 9);
                window = (r == 0) ? 8'd1 : (r == 1) ? 8'd255 : 8'($urandom_range(2, 40));
                base = 8'($urandom_range(40, 215));
                last_phase = cal_plan.phase;
            end
            r = $urandom_range(0, 9);
            if (cal_plan.phase == pcs_pkg::PH_WAIT_LOW)
                margin = (cal_plan.center > 0) ?
                         8'($urandom_range(0, cal_plan.center - 1)) : 8'd0;
            else if (cal_plan.phase == pcs_pkg::PH_WAIT_HIGH)
                margin = (cal_plan.center < 255) ?
                         8'($urandom_range(0, 254 - cal_plan.center)) : 8'd0;
            else
                margin = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
            if (cal_plan.phase == pcs_pkg::PH_GRACE_LOW && !hit_boundary)
                grace = cal_plan.elapsed + 16'($urandom_range(2, 20));
            else if (cal_plan.phase == pcs_pkg::PH_GRACE_LOW ||
                     cal_plan.phase == pcs_pkg::PH_GRACE_HIGH)
                grace = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
            else
                grace = 16'($urandom_range(0, 60));
            write_reg(pcs_pkg::REG_STABLE_WINDOW, {8'($urandom), window});
            write_reg(pcs_pkg::REG_CHANGE_MARGIN, {8'($urandom), margin});
            write_reg(pcs_pkg::REG_GRACE_TICKS, grace);
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, 16'($urandom));
            @(negedge clk);
            if (cal_plan.phase == pcs_pkg::PH_GRACE_LOW && !hit_boundary)
            begin
                // one tick short of the grace length, then exactly on it
                hit_boundary = 1;
                while (cal_plan.elapsed < grace - 16'd1)
                    queue_item(pcs_pkg::CMD_TICK, 8'($urandom));
                queue_item(pcs_pkg::CMD_SAMPLE, 8'($urandom));
                queue_item(pcs_pkg::CMD_TICK, 8'($urandom));
                queue_item(pcs_pkg::CMD_SAMPLE, 8'($urandom));
            end
            else
            begin
                noisy = ($urandom_range(0, 3) == 0);
                repeat ($urandom_range(20, 80))
                begin
                    w = gen_item(cal_plan, cal_cfg, base, noisy);
                    queue_item(w.cmd, w.sample);
                    random_words = random_words + 1;
                end
            end
            wait_drained;
            segment = segment + 1;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_status.size() != 0)
            $display("%0t: %0d status words never arrived", $time, expected_status.size());
        if (errors == 0 && expected_status.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pcs_pkg.sv
sv/pcs_cfg.sv
sv/pcs_step.sv
sv/paddle_calibration_sequencer.sv
tb/sv/paddle_calibration_sequencer_test.sv
